// ----- hdl/idn_pkg.sv -----
// ----------------------------------------------------------------------------
// idn_pkg
// Shared widths, character codes, calendar tables and the record that passes
// between the parser and the converter of the ISO date to day number block.
// ----------------------------------------------------------------------------
package idn_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 7;
  localparam int unsigned DayW    = 7;
  localparam int unsigned DaysW   = 23;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PosW-1:0] PosDash1 = 4'd4;
  localparam logic [PosW-1:0] PosDash2 = 4'd7;
  localparam logic [PosW-1:0] PosLast  = 4'd9;
  localparam logic [PosW-1:0] PosSat   = 4'd15;

  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;
  localparam logic [CharW-1:0] CharDash = 8'h2d;

  localparam logic [YearW-1:0] YearMinRst = 14'd1900;
  localparam logic [YearW-1:0] YearMaxRst = 14'd2999;

  // floor(x / 100) = (x * 5243) >> 19 for x below 2**15
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int unsigned RecipShift = 19;

  // 146097 (one shifted era) + 719468 (March-based epoch) + 1 (day from one)
  localparam logic [23:0] EpochOffset = 24'd865566;

  typedef enum logic [CfgIdxW-1:0] {
    CfgYearMin = 2'd0,
    CfgYearMax = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic              fmt_ok;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_fields_t;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Day of a year that starts on March 1st, for the first of month m
  function automatic logic [8:0] march_doy(input logic [3:0] m);
    logic [8:0] doy;
    case (m)
      4'd1:    doy = 9'd306;
      4'd2:    doy = 9'd337;
      4'd3:    doy = 9'd0;
      4'd4:    doy = 9'd31;
      4'd5:    doy = 9'd61;
      4'd6:    doy = 9'd92;
      4'd7:    doy = 9'd122;
      4'd8:    doy = 9'd153;
      4'd9:    doy = 9'd184;
      4'd10:   doy = 9'd214;
      4'd11:   doy = 9'd245;
      4'd12:   doy = 9'd275;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

// ----- hdl/idn_parser.sv -----
// ----------------------------------------------------------------------------
// idn_parser
// Input register and character parser: tracks the position, gathers the year,
// month and day digits, checks the format and hands a date record onward on
// the final character.
// ----------------------------------------------------------------------------
module idn_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [idn_pkg::CharW-1:0]     char_code_i,
  input  logic                          last_char_i,
  output logic                          fin_valid_o,
  output idn_pkg::date_fields_t         fin_o,
  input  logic                          fin_ready_i
);

  logic                         in_valid_q;
  logic [idn_pkg::CharW-1:0]    char_q;
  logic                         last_q;

  logic [idn_pkg::PosW-1:0]     pos_q, pos_d;
  logic [idn_pkg::YearW-1:0]    year_q, year_d, year_upd;
  logic [idn_pkg::MonthW-1:0]   month_q, month_d, month_upd;
  logic [idn_pkg::DayW-1:0]     day_q, day_d, day_upd;
  logic                         fmt_q, fmt_d, fmt_upd;

  logic                         fin_valid_q;
  idn_pkg::date_fields_t        fin_q;

  logic                         in_accept;
  logic                         consume;
  logic                         fin_load;
  logic                         is_digit;
  logic [3:0]                   digit;

  assign consume    = in_valid_q && (!last_q || !fin_valid_q || fin_ready_i);
  assign fin_load   = consume && last_q;
  assign in_stall_o = in_valid_q && !consume;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_digit = (char_q >= idn_pkg::CharZero) && (char_q <= idn_pkg::CharNine);
  assign digit    = 4'(char_q - idn_pkg::CharZero);

  always_comb begin
    year_upd  = year_q;
    month_upd = month_q;
    day_upd   = day_q;
    fmt_upd   = fmt_q;
    if ((pos_q == idn_pkg::PosDash1) || (pos_q == idn_pkg::PosDash2)) begin
      if (char_q != idn_pkg::CharDash) begin
        fmt_upd = 1'b0;
      end
    end else if (pos_q <= idn_pkg::PosLast) begin
      if (!is_digit) begin
        fmt_upd = 1'b0;
      end else if (pos_q < idn_pkg::PosDash1) begin
        year_upd = idn_pkg::YearW'({year_q, 3'b000} + {year_q, 1'b0} + {10'd0, digit});
      end else if (pos_q < idn_pkg::PosDash2) begin
        month_upd = idn_pkg::MonthW'({month_q, 3'b000} + {month_q, 1'b0} + {3'd0, digit});
      end else begin
        day_upd = idn_pkg::DayW'({day_q, 3'b000} + {day_q, 1'b0} + {3'd0, digit});
      end
    end else begin
      fmt_upd = 1'b0;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    fmt_d   = fmt_q;
    if (consume) begin
      if (last_q) begin
        pos_d   = '0;
        year_d  = '0;
        month_d = '0;
        day_d   = '0;
        fmt_d   = 1'b1;
      end else begin
        pos_d   = (pos_q == idn_pkg::PosSat) ? pos_q : pos_q + 4'd1;
        year_d  = year_upd;
        month_d = month_upd;
        day_d   = day_upd;
        fmt_d   = fmt_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pos_q       <= '0;
      year_q      <= '0;
      month_q     <= '0;
      day_q       <= '0;
      fmt_q       <= 1'b1;
      fin_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      pos_q   <= pos_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      fmt_q   <= fmt_d;
      if (fin_load) begin
        fin_valid_q <= 1'b1;
      end else if (fin_ready_i) begin
        fin_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= char_code_i;
      last_q <= last_char_i;
    end
    if (fin_load) begin
      fin_q.fmt_ok <= fmt_upd && (pos_q == idn_pkg::PosLast);
      fin_q.year   <= year_upd;
      fin_q.month  <= month_upd;
      fin_q.day    <= day_upd;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

endmodule

// ----- hdl/idn_convert.sv -----
// ----------------------------------------------------------------------------
// idn_convert
// Date checker and day count converter with the result register: validates
// month, day and year limits and turns the date into days since 1970-01-01.
// ----------------------------------------------------------------------------
module idn_convert (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fin_valid_i,
  input  idn_pkg::date_fields_t             fin_i,
  output logic                              fin_ready_o,
  input  logic [idn_pkg::YearW-1:0]         year_min_i,
  input  logic [idn_pkg::YearW-1:0]         year_max_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              date_valid_o,
  output logic signed [idn_pkg::DaysW-1:0]  day_number_o
);

  logic                              out_valid_q;
  logic                              date_valid_q;
  logic signed [idn_pkg::DaysW-1:0]  day_number_q;

  logic        load;
  logic [3:0]  m4;
  logic        month_ok, year_ok, day_ok, leap, cent, valid;
  logic [26:0] y_prod;
  logic [7:0]  y_q100;
  logic [13:0] y_back;
  logic [4:0]  lim;
  logic [14:0] yy;
  logic [27:0] yy_prod;
  logic [8:0]  yy_q100;
  logic [23:0] days_sum;

  assign fin_ready_o = !out_valid_q || !out_stall_i;
  assign load        = fin_valid_i && fin_ready_o;

  assign m4       = fin_i.month[3:0];
  assign month_ok = (fin_i.month >= 7'd1) && (fin_i.month <= 7'd12);
  assign year_ok  = (fin_i.year >= year_min_i) && (fin_i.year <= year_max_i);

  assign y_prod = 27'(fin_i.year) * 27'(idn_pkg::Recip100);
  assign y_q100 = y_prod[idn_pkg::RecipShift +: 8];
  assign y_back = 14'({6'd0, y_q100} * 14'd100);
  assign cent   = (y_back == fin_i.year);
  assign leap   = ((fin_i.year[1:0] == 2'b00) && !cent) || (cent && (y_q100[1:0] == 2'b00));
  assign lim    = ((m4 == 4'd2) && leap) ? 5'd29 : idn_pkg::month_len(m4);
  assign day_ok = (fin_i.day != '0) && (fin_i.day <= {2'b00, lim});

  assign valid = fin_i.fmt_ok && month_ok && year_ok && day_ok;

  assign yy      = 15'(fin_i.year) + 15'd400 - ((fin_i.month <= 7'd2) ? 15'd1 : 15'd0);
  assign yy_prod = 28'(yy) * 28'(idn_pkg::Recip100);
  assign yy_q100 = yy_prod[idn_pkg::RecipShift +: 9];

  assign days_sum = 24'(yy) * 24'd365
                  + 24'(yy[14:2])
                  + 24'(yy_q100[8:2])
                  - 24'(yy_q100)
                  + 24'(idn_pkg::march_doy(m4))
                  + 24'(fin_i.day)
                  - idn_pkg::EpochOffset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      date_valid_q <= valid;
      day_number_q <= valid ? $signed(days_sum[idn_pkg::DaysW-1:0]) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign date_valid_o = date_valid_q;
  assign day_number_o = day_number_q;

endmodule

// ----- hdl/iso_date_to_day_number.sv -----
// ----------------------------------------------------------------------------
// iso_date_to_day_number
// Reads a YYYY-MM-DD string one character per request and gives, on the
// marked final character, a validity flag and the day count since 1970-01-01.
// ----------------------------------------------------------------------------
// One character request is taken every clock cycle unless in_stall_o is high.
// After its final character is accepted, a result passes through three
// registers: the input register, the parser that gathers the digits and
// emits the date record, and the converter that checks the calendar and
// computes the day count. Stalls on the result side back up through those
// three registers. Year limits are written at any time through the
// configuration port, which is always ready; write them only while no string
// is in flight.
module iso_date_to_day_number (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [idn_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  logic [idn_pkg::YearW-1:0]              cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [idn_pkg::CharW-1:0]              char_code_i,
  input  logic                                   last_char_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   date_valid_o,
  output logic signed [idn_pkg::DaysW-1:0]       day_number_o
);

  logic [idn_pkg::YearW-1:0] year_min_q;
  logic [idn_pkg::YearW-1:0] year_max_q;

  logic                      fin_valid;
  logic                      fin_ready;
  idn_pkg::date_fields_t     fin;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_min_q <= idn_pkg::YearMinRst;
      year_max_q <= idn_pkg::YearMaxRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (idn_pkg::cfg_idx_e'(cfg_index_i))
        idn_pkg::CfgYearMin: year_min_q <= cfg_data_i;
        idn_pkg::CfgYearMax: year_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  idn_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .fin_valid_o (fin_valid),
    .fin_o       (fin),
    .fin_ready_i (fin_ready)
  );

  idn_convert u_convert (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fin_valid_i  (fin_valid),
    .fin_i        (fin),
    .fin_ready_o  (fin_ready),
    .year_min_i   (year_min_q),
    .year_max_i   (year_max_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .date_valid_o (date_valid_o),
    .day_number_o (day_number_o)
  );

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !date_valid_o) |-> (day_number_o == '0))
    else $error("invalid result carries a nonzero day number");

  a_cfg_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o && (cfg_index_i == idn_pkg::CfgYearMin))
      |=> (year_min_q == $past(cfg_data_i)))
    else $error("year_min write lost");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fin_valid))
    else $error("result without a date record");

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_valid && !fin_ready) |=> (fin_valid && $stable(fin)))
    else $error("date record dropped under stall");
`endif

endmodule

// ----- verif/tb_iso_date_to_day_number.sv -----
// ----------------------------------------------------------------------------
// tb_iso_date_to_day_number
// Streams YYYY-MM-DD strings, intact, damaged and random, into the date
// converter through several year-limit settings and idling patterns, and
// checks every result against a parser and calendar model kept in step with
// each accepted character request.
// ----------------------------------------------------------------------------
module tb_iso_date_to_day_number;
  timeunit 1ns;
  timeprecision 1ps;

  import idn_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int SettleWait  = 6;
  localparam int TextsPerRun = 17;
  localparam int MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef enum logic [2:0] {
    TextIntact,
    TextSwapped,
    TextTruncated,
    TextExtended,
    TextNoise
  } text_kind_e;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } date_char_t;

  typedef struct packed {
    logic                    date_valid;
    logic signed [DaysW-1:0] day_number;
  } day_result_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [YearW-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [CharW-1:0]     char_code_i = '0;
  logic                 last_char_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 date_valid_o;
  logic signed [DaysW-1:0] day_number_o;

  date_char_t  pending_chars [$];
  day_result_t due_days [$];
  logic        char_held     = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          mismatches    = 0;
  int          cycle_count   = 0;

  logic [YearW-1:0]  year_lo    = YearMinRst;
  logic [YearW-1:0]  year_hi    = YearMaxRst;
  logic [PosW-1:0]   text_pos   = '0;
  logic [YearW-1:0]  year_acc   = '0;
  logic [MonthW-1:0] month_acc  = '0;
  logic [DayW-1:0]   day_acc    = '0;
  logic              text_ok    = 1'b1;

  iso_date_to_day_number dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .date_valid_o (date_valid_o),
    .day_number_o (day_number_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic is_leap(input int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int days_from_civil(input int y, input int m, input int d);
    int yy, era, yoe, mp, doy, doe;
    yy  = y + 400 - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy % 400;
    mp  = (m > 2) ? (m - 3) : (m + 9);
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return (era - 1) * 146097 + doe - 719468;
  endfunction

  function automatic int month_limit(input int y, input int m);
    if (m < 1 || m > 12) return 31;
    if (m == 2 && is_leap(y)) return 29;
    return MonthDays[m-1];
  endfunction

  // Advance the parser by one character; returns 1 when a result is due.
  function automatic logic parse_date_char(input date_char_t ch, output day_result_t res);
    logic [PosW-1:0] at;
    logic            digit;
    int              dv, y, m, d;
    logic            ok;
    at    = text_pos;
    digit = (ch.code >= CharZero) && (ch.code <= CharNine);
    dv    = digit ? int'(ch.code - CharZero) : 0;
    res   = '0;
    if (at == PosDash1 || at == PosDash2) begin
      if (ch.code != CharDash) text_ok = 1'b0;
    end else if (at <= PosLast) begin
      if (!digit) begin
        text_ok = 1'b0;
      end else if (at < PosDash1) begin
        year_acc = YearW'(year_acc * 10 + dv);
      end else if (at < PosDash2) begin
        month_acc = MonthW'(month_acc * 10 + dv);
      end else begin
        day_acc = DayW'(day_acc * 10 + dv);
      end
    end else begin
      text_ok = 1'b0;
    end
    if (text_pos != PosSat) text_pos = text_pos + 1'b1;
    if (!ch.last) return 1'b0;
    y  = year_acc;
    m  = month_acc;
    d  = day_acc;
    ok = text_ok && (at == PosLast) && (m >= 1) && (m <= 12) && (y >= year_lo) && (y <= year_hi);
    if (ok) ok = (d >= 1) && (d <= month_limit(y, m));
    if (ok) begin
      res.date_valid = 1'b1;
      res.day_number = DaysW'(days_from_civil(y, m, d));
    end
    text_pos  = '0;
    year_acc  = '0;
    month_acc = '0;
    day_acc   = '0;
    text_ok   = 1'b1;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch %s: expected %0d, got %0d", what, want, got);
    mismatches++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      in_valid_i  <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      if (!char_held && pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
        char_held = 1'b1;
      in_valid_i <= char_held;
      if (char_held) begin
        char_code_i <= pending_chars[0].code;
        last_char_i <= pending_chars[0].last;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    day_result_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("iso_date_to_day_number verification failed");
      $finish;
    end else if (rst_ni === 1'b1) begin
      if (in_valid_i && !in_stall_o) begin
        char_held = 1'b0;
        if (parse_date_char(pending_chars.pop_front(), want))
          due_days.insert(due_days.size(), want);
      end
      if (out_valid_o && !out_stall_i) begin
        if (due_days.size() == 0) begin
          report_mismatch("unexpected result, day_number", 0, int'(day_number_o));
        end else begin
          want = due_days.pop_front();
          if (date_valid_o !== want.date_valid)
            report_mismatch("date_valid", int'(want.date_valid), int'(date_valid_o));
          if (day_number_o !== want.day_number)
            report_mismatch("day_number", int'(want.day_number), int'(day_number_o));
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_chars.size() != 0 || char_held || due_days.size() != 0) @(negedge clk_i);
    repeat (SettleWait) @(negedge clk_i);
  endtask

  task automatic write_year_limit(input logic [CfgIdxW-1:0] idx, input logic [YearW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CfgYearMin: year_lo = val;
      CfgYearMax: year_hi = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_text(input logic [CharW-1:0] txt [$]);
    date_char_t ch;
    foreach (txt[i]) begin
      ch.code = txt[i];
      ch.last = (i == txt.size() - 1);
      pending_chars.insert(pending_chars.size(), ch);
    end
  endtask

  task automatic queue_literal(input string s);
    logic [CharW-1:0] txt [$];
    for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
    queue_text(txt);
  endtask

  function automatic logic [CharW-1:0] digit_char(input int v);
    return CharZero + CharW'(v % 10);
  endfunction

  function automatic int pick_year();
    int lo, hi;
    lo = year_lo;
    hi = (year_hi > 9999) ? 9999 : int'(year_hi);
    case ($urandom_range(0, 5))
      0, 1: return (lo <= hi) ? int'($urandom_range(hi, lo)) : int'($urandom_range(0, 9999));
      2: begin
        case ($urandom_range(0, 3))
          0: lo = lo - 1;
          1: lo = lo;
          2: lo = hi;
          default: lo = hi + 1;
        endcase
        return (lo < 0) ? 0 : ((lo > 9999) ? 9999 : lo);
      end
      3: return $urandom_range(0, 99) * 100;
      4: return $urandom_range(0, 2499) * 4;
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  task automatic queue_random_text();
    logic [CharW-1:0] txt [$];
    text_kind_e kind;
    int y, m, d, lim, n;
    case ($urandom_range(0, 15))
      12: kind = TextSwapped;
      13: kind = TextTruncated;
      14: kind = TextExtended;
      15: kind = TextNoise;
      default: kind = TextIntact;
    endcase
    y = pick_year();
    case ($urandom_range(0, 9))
      8: m = 2;
      9: m = $urandom_range(0, 1) ? 0 : int'($urandom_range(13, 99));
      default: m = $urandom_range(1, 12);
    endcase
    lim = month_limit(y, m);
    case ($urandom_range(0, 7))
      4: d = lim;
      5: d = lim + 1;
      6: d = 0;
      7: d = $urandom_range(0, 99);
      default: d = $urandom_range(1, lim);
    endcase
    txt = '{digit_char(y / 1000), digit_char(y / 100), digit_char(y / 10), digit_char(y),
            CharDash, digit_char(m / 10), digit_char(m), CharDash,
            digit_char(d / 10), digit_char(d)};
    case (kind)
      TextSwapped: txt[$urandom_range(0, 9)] = CharW'($urandom_range(0, 255));
      TextTruncated: begin
        n = $urandom_range(1, 9);
        while (txt.size() > n) void'(txt.pop_back());
      end
      TextExtended: begin
        n = $urandom_range(1, 10);
        repeat (n) txt.insert(txt.size(), $urandom_range(0, 3) ?
                              digit_char($urandom_range(0, 9)) :
                              CharW'($urandom_range(0, 255)));
      end
      TextNoise: begin
        txt = {};
        n = $urandom_range(1, 20);
        repeat (n) txt.insert(txt.size(), CharW'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    queue_text(txt);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_literal("1970-01-01");
    queue_literal("2000-02-29");
    queue_literal("1900-02-29");
    queue_literal("Z");
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          write_year_limit(CfgYearMin, '0);
          write_year_limit(CfgYearMax, YearW'(9999));
          send_idle_pct = 75;
          stall_pct     = 0;
        end
        2: begin
          write_year_limit(CfgYearMax, '1);
          write_year_limit(CfgSpare, YearW'(5000));
          send_idle_pct = 0;
          stall_pct     = 75;
        end
        3: begin
          write_year_limit(CfgYearMin, YearW'(2000));
          write_year_limit(CfgYearMax, YearW'(2000));
          send_idle_pct = 28;
          stall_pct     = 28;
        end
        4: begin
          write_year_limit(CfgYearMin, YearW'(5000));
          write_year_limit(CfgYearMax, YearW'(100));
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        5: begin
          write_year_limit(CfgYearMin, YearW'($urandom_range(0, 3000)));
          write_year_limit(CfgYearMax, YearW'($urandom_range(9999, year_lo)));
          send_idle_pct = 28;
          stall_pct     = 28;
        end
        default: begin
          write_year_limit(CfgYearMin, YearW'(9999));
          write_year_limit(CfgYearMax, YearW'(9999));
          send_idle_pct = 75;
          stall_pct     = 75;
        end
      endcase
      for (int n = 0; n < TextsPerRun; n++) begin
        if (ph == 3 && n == TextsPerRun / 2) wait_idle();
        queue_random_text();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("iso_date_to_day_number verification clean");
    end else begin
      $display("iso_date_to_day_number verification failed");
    end
    $finish;
  end

endmodule
